/* sv/crast_pkg.sv */
// Shared constants and codes for the circle rasterizer.
`timescale 1ns / 1ps

package crast_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 11;
    localparam int DEC_BITS    = RADIUS_BITS + 3;
    localparam int OUT_BITS    = COORD_BITS + 2;
    // working width for the decision update, wide enough that nothing wraps
    localparam int WIDE_BITS   = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 4;

    localparam int S_TDATA_BITS = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((3 * OUT_BITS + 7) / 8) * 8;

    localparam int BEAT_BITS     = 3;
    localparam int BEATS_OUTLINE = 8;
    localparam int BEATS_FILL    = 4;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic MODE_OUTLINE = 1'b0;
    localparam logic MODE_FILL    = 1'b1;

endpackage

/* sv/circle_rasterizer_top.sv */
// Circle rasterizer: Andres iteration with a beat emitter and a result register.
`timescale 1ns / 1ps

// A start request (s_tuser = 0) loads centre and radius and gives no result.
// An advance request (s_tuser = 1) runs one Andres iteration in the cycle it
// is taken and hands the step to the emitter, which puts out eight outline
// points (draw_mode 0) or four fill spans (draw_mode 1), one per cycle while
// the result port is not stalled. The next request is taken in the cycle the
// last beat of the previous step moves into the result register, so steps
// follow each other without gaps. m_tlast marks the last result of a step,
// m_tuser additionally marks the circle's final step. An advance with no
// circle in progress is taken and gives nothing.
module circle_rasterizer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: draw_mode
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [11:0] center_x, [23:12] center_y, [34:24] radius, rest zero
    input  logic [crast_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [0] opcode
    input  logic                                s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [13:0] x_start, [27:14] x_end, [41:28] row_y, rest zero
    output logic [crast_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                                m_tlast,
    // [0] done_res
    output logic                                m_tuser
);

    localparam int C  = crast_pkg::COORD_BITS;
    localparam int R  = crast_pkg::RADIUS_BITS;
    localparam int DB = crast_pkg::DEC_BITS;
    localparam int OB = crast_pkg::OUT_BITS;
    localparam int W  = crast_pkg::WIDE_BITS;
    localparam int BB = crast_pkg::BEAT_BITS;

    // circle state
    logic                 draw_mode_reg;
    logic                 active_reg,   active_next;
    logic [C-1:0]         offset_x_reg, offset_x_next;
    logic [C-1:0]         offset_y_reg, offset_y_next;
    logic signed [DB-1:0] decision_reg, decision_next;
    logic [C-1:0]         cur_cx_reg,   cur_cx_next;
    logic [C-1:0]         cur_cy_reg,   cur_cy_next;
    logic [R-1:0]         cur_r_reg,    cur_r_next;

    // emitter: snapshot of the step being sent out
    logic                 busy_reg, busy_next;
    logic [BB-1:0]        beat_reg, beat_next;
    logic [C-1:0]         snap_cx_reg, snap_cy_reg, snap_ox_reg, snap_oy_reg;
    logic                 snap_mode_reg, snap_fin_reg;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [OB-1:0]        xs_reg, xe_reg, y_reg;
    logic                 last_reg, done_reg;

    logic                 s_fire, emit_fire, last_beat, do_step;
    logic [C-1:0]         in_cx, in_cy;
    logic [R-1:0]         in_r;
    logic [BB-1:0]        last_idx;

    logic signed [W-1:0]  d_w, ox_w, oy_w, r_w, nx_w, ny_w, d_new_w, start_d_w;
    logic                 fin;

    logic [OB-1:0]        cx_o, cy_o, ox_o, oy_o;
    logic [OB-1:0]        cx_p_ox, cx_m_ox, cx_p_oy, cx_m_oy;
    logic [OB-1:0]        cy_p_ox, cy_m_ox, cy_p_oy, cy_m_oy;
    logic [OB-1:0]        beat_xs, beat_xe, beat_y;

    assign in_cx = s_tdata[C-1:0];
    assign in_cy = s_tdata[2*C-1:C];
    assign in_r  = s_tdata[2*C+R-1:2*C];

    assign cfg_ready = 1'b1;

    // ---------------- emitter handshake ----------------
    assign last_idx  = (snap_mode_reg == crast_pkg::MODE_FILL) ? BB'(crast_pkg::BEATS_FILL - 1)
                                                               : BB'(crast_pkg::BEATS_OUTLINE - 1);
    assign last_beat = (beat_reg == last_idx);
    assign emit_fire = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !busy_reg || (emit_fire && last_beat);
    assign s_fire    = s_tvalid && s_tready;
    assign do_step   = s_fire && (s_tuser == crast_pkg::OP_ADVANCE) && active_reg;

    // ---------------- Andres update ----------------
    always_comb begin
        d_w  = W'(decision_reg);
        ox_w = W'({1'b0, offset_x_reg});
        oy_w = W'({1'b0, offset_y_reg});
        r_w  = W'({1'b0, cur_r_reg});
        nx_w = ox_w;
        ny_w = oy_w;
        priority if (d_w >= (ox_w <<< 1)) begin
            d_new_w = d_w - (ox_w <<< 1) - W'(1);
            nx_w    = ox_w + W'(1);
        end else if (d_w < ((r_w - oy_w) <<< 1)) begin
            d_new_w = d_w + (oy_w <<< 1) - W'(1);
            ny_w    = oy_w - W'(1);
        end else begin
            d_new_w = d_w + ((oy_w - ox_w - W'(1)) <<< 1);
            ny_w    = oy_w - W'(1);
            nx_w    = ox_w + W'(1);
        end
        fin       = (ny_w < nx_w);
        start_d_w = W'({1'b0, in_r}) - W'(1);
    end

    always_comb begin
        active_next   = active_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        decision_next = decision_reg;
        cur_cx_next   = cur_cx_reg;
        cur_cy_next   = cur_cy_reg;
        cur_r_next    = cur_r_reg;
        if (s_fire && (s_tuser == crast_pkg::OP_START)) begin
            cur_cx_next   = in_cx;
            cur_cy_next   = in_cy;
            cur_r_next    = in_r;
            offset_x_next = '0;
            offset_y_next = C'({1'b0, in_r});
            decision_next = start_d_w[DB-1:0];
            active_next   = 1'b1;
        end else if (do_step) begin
            offset_x_next = nx_w[C-1:0];
            offset_y_next = fin ? '0 : ny_w[C-1:0];
            decision_next = d_new_w[DB-1:0];
            if (fin) begin
                active_next = 1'b0;
            end
        end
    end

    // ---------------- beat generation ----------------
    always_comb begin
        cx_o = OB'(snap_cx_reg);
        cy_o = OB'(snap_cy_reg);
        ox_o = OB'(snap_ox_reg);
        oy_o = OB'(snap_oy_reg);
        cx_p_ox = cx_o + ox_o;
        cx_m_ox = cx_o - ox_o;
        cx_p_oy = cx_o + oy_o;
        cx_m_oy = cx_o - oy_o;
        cy_p_ox = cy_o + ox_o;
        cy_m_ox = cy_o - ox_o;
        cy_p_oy = cy_o + oy_o;
        cy_m_oy = cy_o - oy_o;
        unique case ({snap_mode_reg, beat_reg})
            {crast_pkg::MODE_OUTLINE, 3'd0}: begin beat_xs = cx_p_ox; beat_xe = cx_p_ox; beat_y = cy_p_oy; end
            {crast_pkg::MODE_OUTLINE, 3'd1}: begin beat_xs = cx_p_oy; beat_xe = cx_p_oy; beat_y = cy_p_ox; end
            {crast_pkg::MODE_OUTLINE, 3'd2}: begin beat_xs = cx_m_ox; beat_xe = cx_m_ox; beat_y = cy_p_oy; end
            {crast_pkg::MODE_OUTLINE, 3'd3}: begin beat_xs = cx_m_oy; beat_xe = cx_m_oy; beat_y = cy_p_ox; end
            {crast_pkg::MODE_OUTLINE, 3'd4}: begin beat_xs = cx_p_ox; beat_xe = cx_p_ox; beat_y = cy_m_oy; end
            {crast_pkg::MODE_OUTLINE, 3'd5}: begin beat_xs = cx_p_oy; beat_xe = cx_p_oy; beat_y = cy_m_ox; end
            {crast_pkg::MODE_OUTLINE, 3'd6}: begin beat_xs = cx_m_ox; beat_xe = cx_m_ox; beat_y = cy_m_oy; end
            {crast_pkg::MODE_OUTLINE, 3'd7}: begin beat_xs = cx_m_oy; beat_xe = cx_m_oy; beat_y = cy_m_ox; end
            {crast_pkg::MODE_FILL,    3'd0}: begin beat_xs = cx_m_oy; beat_xe = cx_p_oy; beat_y = cy_p_ox; end
            {crast_pkg::MODE_FILL,    3'd1}: begin beat_xs = cx_m_ox; beat_xe = cx_p_ox; beat_y = cy_p_oy; end
            {crast_pkg::MODE_FILL,    3'd2}: begin beat_xs = cx_m_ox; beat_xe = cx_p_ox; beat_y = cy_m_oy; end
            {crast_pkg::MODE_FILL,    3'd3}: begin beat_xs = cx_m_oy; beat_xe = cx_p_oy; beat_y = cy_m_ox; end
            default:                         begin beat_xs = cx_o;    beat_xe = cx_o;    beat_y = cy_o;    end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        beat_next = beat_reg;
        if (emit_fire) begin
            if (last_beat) begin
                busy_next = 1'b0;
            end else begin
                beat_next = beat_reg + BB'(1);
            end
        end
        if (do_step) begin
            busy_next = 1'b1;
            beat_next = '0;
        end
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_mode_reg <= crast_pkg::MODE_OUTLINE;
            active_reg    <= 1'b0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            decision_reg  <= '0;
            cur_cx_reg    <= '0;
            cur_cy_reg    <= '0;
            cur_r_reg     <= '0;
            busy_reg      <= 1'b0;
            beat_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                draw_mode_reg <= cfg_data;
            end
            active_reg   <= active_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            decision_reg <= decision_next;
            cur_cx_reg   <= cur_cx_next;
            cur_cy_reg   <= cur_cy_next;
            cur_r_reg    <= cur_r_next;
            busy_reg     <= busy_next;
            beat_reg     <= beat_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (do_step) begin
            snap_cx_reg   <= cur_cx_reg;
            snap_cy_reg   <= cur_cy_reg;
            snap_ox_reg   <= offset_x_reg;
            snap_oy_reg   <= offset_y_reg;
            snap_mode_reg <= draw_mode_reg;
            snap_fin_reg  <= fin;
        end
        if (emit_fire) begin
            xs_reg   <= beat_xs;
            xe_reg   <= beat_xe;
            y_reg    <= beat_y;
            last_reg <= last_beat;
            done_reg <= last_beat && snap_fin_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = crast_pkg::M_TDATA_BITS'({y_reg, xe_reg, xs_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

`ifndef SYNTHESIS
    // done only ever rides on the closing result of a step
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("done flag on a non-final result");

    // a new request overlaps the emitter only on its closing beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && busy_reg |-> emit_fire && last_beat)
        else $error("request taken mid-step");

    // fill steps never run past their fourth span
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (snap_mode_reg == crast_pkg::MODE_FILL) |-> beat_reg < BB'(crast_pkg::BEATS_FILL))
        else $error("fill beat out of range");

    // the final step of a circle leaves it inactive
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_step && fin |=> !active_reg || $past(s_fire && (s_tuser == crast_pkg::OP_START)))
        else $error("circle still active after final step");
`endif

endmodule

/* bench/tb_circle_rasterizer_top.sv */
// Self-checking bench for the circle rasterizer: predicted points and spans against results.
`timescale 1ns / 1ps

module tb_circle_rasterizer_top;

    typedef struct {
        logic                             op;
        logic [crast_pkg::COORD_BITS-1:0]  cx;
        logic [crast_pkg::COORD_BITS-1:0]  cy;
        logic [crast_pkg::RADIUS_BITS-1:0] r;
    } request_t;

    typedef struct {
        logic [crast_pkg::OUT_BITS-1:0] xs;
        logic [crast_pkg::OUT_BITS-1:0] xe;
        logic [crast_pkg::OUT_BITS-1:0] y;
        logic                           last;
        logic                           done;
    } span_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic                               cfg_data  = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [crast_pkg::S_TDATA_BITS-1:0] s_tdata   = '0;
    logic                               s_tuser   = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [crast_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                               m_tlast;
    logic                               m_tuser;

    request_t pending_requests[$];
    span_t    spans_due[$];
    request_t on_bus;
    logic     bus_busy   = 1'b0;
    logic     bursts_on  = 1'b1;
    int       gap_left   = 0;
    int       stall_left = 0;
    int       mismatches = 0;
    span_t    want;

    // tracked rasterizer state
    logic trk_mode   = crast_pkg::MODE_OUTLINE;
    logic trk_active = 1'b0;
    int   trk_ox     = 0;
    int   trk_oy     = 0;
    int   trk_dec    = 0;
    int   trk_cx     = 0;
    int   trk_cy     = 0;
    int   trk_r      = 0;

    circle_rasterizer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic push_span(input int xs, input int xe, input int y,
                             input logic last, input logic done);
        span_t sp;
        sp.xs   = crast_pkg::OUT_BITS'(xs);
        sp.xe   = crast_pkg::OUT_BITS'(xe);
        sp.y    = crast_pkg::OUT_BITS'(y);
        sp.last = last;
        sp.done = done;
        spans_due.push_back(sp);
    endtask

    // one Andres iteration per advance; results queued in emission order
    task automatic trace_step(input request_t rq);
        int   cx, cy, ox, oy, d, nx, ny;
        logic fin;
        logic signed [crast_pkg::DEC_BITS-1:0] dw;
        if (rq.op == crast_pkg::OP_START) begin
            trk_cx     = int'(rq.cx);
            trk_cy     = int'(rq.cy);
            trk_r      = int'(rq.r);
            trk_ox     = 0;
            trk_oy     = int'(rq.r);
            dw         = crast_pkg::DEC_BITS'(int'(rq.r) - 1);
            trk_dec    = int'(dw);
            trk_active = 1'b1;
        end else if (trk_active) begin
            cx = trk_cx;
            cy = trk_cy;
            ox = trk_ox;
            oy = trk_oy;
            d  = trk_dec;
            nx = ox;
            ny = oy;
            if (d >= 2 * ox) begin
                d  = d - (2 * ox + 1);
                nx = ox + 1;
            end else if (d < 2 * (trk_r - oy)) begin
                d  = d + 2 * oy - 1;
                ny = oy - 1;
            end else begin
                d  = d + 2 * (oy - ox - 1);
                ny = oy - 1;
                nx = ox + 1;
            end
            fin = (ny < nx);
            if (trk_mode == crast_pkg::MODE_OUTLINE) begin
                push_span(cx + ox, cx + ox, cy + oy, 1'b0, 1'b0);
                push_span(cx + oy, cx + oy, cy + ox, 1'b0, 1'b0);
                push_span(cx - ox, cx - ox, cy + oy, 1'b0, 1'b0);
                push_span(cx - oy, cx - oy, cy + ox, 1'b0, 1'b0);
                push_span(cx + ox, cx + ox, cy - oy, 1'b0, 1'b0);
                push_span(cx + oy, cx + oy, cy - ox, 1'b0, 1'b0);
                push_span(cx - ox, cx - ox, cy - oy, 1'b0, 1'b0);
                push_span(cx - oy, cx - oy, cy - ox, 1'b1, fin);
            end else begin
                push_span(cx - oy, cx + oy, cy + ox, 1'b0, 1'b0);
                push_span(cx - ox, cx + ox, cy + oy, 1'b0, 1'b0);
                push_span(cx - ox, cx + ox, cy - oy, 1'b0, 1'b0);
                push_span(cx - oy, cx + oy, cy - ox, 1'b1, fin);
            end
            trk_ox  = nx & ((1 << crast_pkg::COORD_BITS) - 1);
            trk_oy  = fin ? 0 : (ny & ((1 << crast_pkg::COORD_BITS) - 1));
            dw      = crast_pkg::DEC_BITS'(d);
            trk_dec = int'(dw);
            if (fin)
                trk_active = 1'b0;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                trace_step(on_bus);
                bus_busy = 1'b0;
            end
            if (!bus_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    on_bus   = pending_requests.pop_front();
                    bus_busy = 1'b1;
                    s_tdata  <= crast_pkg::S_TDATA_BITS'({on_bus.r, on_bus.cy, on_bus.cx});
                    s_tuser  <= on_bus.op;
                    s_tvalid <= 1'b1;
                    if (bursts_on && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 15);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (spans_due.size() == 0) begin
                    report_mismatch($sformatf("result with none due, tdata %h", m_tdata));
                end else begin
                    want = spans_due.pop_front();
                    if (m_tdata[crast_pkg::OUT_BITS-1:0] !== want.xs)
                        report_mismatch($sformatf("x_start %h, want %h",
                                                  m_tdata[crast_pkg::OUT_BITS-1:0], want.xs));
                    if (m_tdata[2*crast_pkg::OUT_BITS-1:crast_pkg::OUT_BITS] !== want.xe)
                        report_mismatch($sformatf("x_end %h, want %h",
                            m_tdata[2*crast_pkg::OUT_BITS-1:crast_pkg::OUT_BITS], want.xe));
                    if (m_tdata[3*crast_pkg::OUT_BITS-1:2*crast_pkg::OUT_BITS] !== want.y)
                        report_mismatch($sformatf("row_y %h, want %h",
                            m_tdata[3*crast_pkg::OUT_BITS-1:2*crast_pkg::OUT_BITS], want.y));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
                    if (m_tuser !== want.done)
                        report_mismatch($sformatf("done_res %b, want %b", m_tuser, want.done));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (bursts_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    task automatic add_request(input logic op, input int cx, input int cy, input int r);
        request_t rq;
        rq.op = op;
        rq.cx = crast_pkg::COORD_BITS'(cx);
        rq.cy = crast_pkg::COORD_BITS'(cy);
        rq.r  = crast_pkg::RADIUS_BITS'(r);
        pending_requests.push_back(rq);
    endtask

    task automatic add_circle(input int cx, input int cy, input int r, input int steps);
        add_request(crast_pkg::OP_START, cx, cy, r);
        repeat (steps) add_request(crast_pkg::OP_ADVANCE, 0, 0, 0);
    endtask

    // mostly whole small circles, some large ones cut short, some noise
    task automatic add_random_mix(input int count);
        int added;
        int r;
        int steps;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 9) == 0) begin
                add_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
                added++;
            end else begin
                if ($urandom_range(0, 6) == 0) begin
                    r     = $urandom_range(0, (1 << crast_pkg::RADIUS_BITS) - 1);
                    steps = $urandom_range(1, 6);
                end else begin
                    r     = $urandom_range(0, 16);
                    // y - x falls by at least one per step, so r + 1 always finishes
                    steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, r / 2 + 1) : r + 1;
                end
                add_circle($urandom, $urandom, r, steps);
                added += steps + 1;
            end
        end
    endtask

    task automatic await_drained;
        while (pending_requests.size() > 0 || bus_busy || spans_due.size() > 0)
            @(posedge aclk);
        // a start or an idle advance leaves nothing to wait for
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        trk_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // outline mode from reset: idle advance, zero radius, wrap at both
        // corners, a circle dropped by a new start
        add_request(crast_pkg::OP_ADVANCE, 0, 0, 0);
        add_circle(2048, 2048, 0, 2);
        add_circle(4095, 4095, 2047, 2);
        add_circle(0, 0, 2047, 2);
        add_circle(100, 200, 3, 1);
        add_circle(10, 20, 1, 3);
        await_drained();

        write_mode(crast_pkg::MODE_FILL);
        add_circle(0, 4095, 2047, 1);
        add_circle(4095, 0, 0, 1);
        add_circle(50, 60, 2, 4);
        await_drained();

        write_mode(crast_pkg::MODE_OUTLINE);
        add_random_mix(87);
        await_drained();

        write_mode(crast_pkg::MODE_FILL);
        add_random_mix(87);
        await_drained();

        write_mode(crast_pkg::MODE_OUTLINE);
        add_random_mix(87);
        await_drained();

        // final stretch runs at full rate on both sides
        write_mode(crast_pkg::MODE_FILL);
        bursts_on = 1'b0;
        add_random_mix(87);
        await_drained();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
